// File: rtl/masked_bar_pixel_writer_unit_macros.svh
// Assertion macros for the masked bar pixel writer.
// Used by the top level only; no other dependencies.
`ifndef MASKED_BAR_PIXEL_WRITER_UNIT_MACROS_SVH
`define MASKED_BAR_PIXEL_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define MBPW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("masked bar pixel writer: same-cycle check failed");

// next-cycle implication
`define MBPW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("masked bar pixel writer: next-cycle check failed");

`endif

// File: rtl/mbpw_pkg.sv
// Shared types, constants and colour expansion for the masked bar pixel writer.
// No dependencies.
`default_nettype none

package mbpw_pkg;

   localparam int unsigned BAR_PIXELS  = 8;   // pixels emitted per bar, 1..8
   localparam int unsigned BAR_STRIDE  = 8;   // storage slots per bar
   localparam int unsigned NUM_BARS    = 2;
   localparam int unsigned NUM_COLOURS = 8;
   localparam int unsigned MAP_FIELDS  = 8;

   localparam logic [7:0]  FIRST_ZONE_RESET = 8'd0;
   localparam logic [23:0] POS_MAP_RESET    = 24'hFAC688;   // identity map

   localparam logic CMD_SET_PIXELS = 1'b0;
   localparam logic CMD_SHUTDOWN   = 1'b1;

   localparam logic REG_FIRST_BAR_ZONE = 1'b0;
   localparam logic REG_POSITION_MAP   = 1'b1;

   // reciprocals for channel * 255 / max, exact over the channel range
   localparam int unsigned R5_SHIFT = 18;
   localparam int unsigned R5_RECIP = (2**R5_SHIFT + 30) / 31;
   localparam int unsigned R5_MUL   = 255 * R5_RECIP;
   localparam int unsigned R6_SHIFT = 20;
   localparam int unsigned R6_RECIP = (2**R6_SHIFT + 62) / 63;
   localparam int unsigned R6_MUL   = 255 * R6_RECIP;

   typedef enum logic [2:0] {
      ST_WRITTEN    = 3'd0,
      ST_RELEASED   = 3'd1,
      ST_BAD_ZONE   = 3'd2,
      ST_MASK_HIGH  = 3'd3,
      ST_BAD_LENGTH = 3'd4,
      ST_SHUTDOWN   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LANE,
      S_MERGE,
      S_EMIT
   } state_type;

   typedef logic [23:0] rgb_type;
   typedef logic [15:0] colour_type;
   typedef colour_type [NUM_COLOURS-1:0] colour_vec_type;
   typedef rgb_type [BAR_STRIDE-1:0] row_type;

   typedef struct packed {
      logic       en;
      logic [2:0] phys;
      rgb_type    rgb;
   } lane_type;

   typedef lane_type [BAR_PIXELS-1:0] lane_vec_type;

   typedef struct packed {
      status_type status;
      logic       bar;
      logic       write;
   } check_type;

   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [26:0] prod;
      prod = 27'(c) * 27'(R5_MUL);
      return prod[R5_SHIFT+7:R5_SHIFT];
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [28:0] prod;
      prod = 29'(c) * 29'(R6_MUL);
      return prod[R6_SHIFT+7:R6_SHIFT];
   endfunction

   function automatic rgb_type expand565(input colour_type c);
      return {expand5(c[15:11]), expand6(c[10:5]), expand5(c[4:0])};
   endfunction

endpackage

`default_nettype wire

// File: rtl/mbpw_check.sv
// Command decode and validation: zone match, mask and length checks.
// Depends on mbpw_pkg.
`default_nettype none

module mbpw_check (
   input  logic                 command,
   input  logic [7:0]           zone,
   input  logic [15:0]          mask,
   input  logic [7:0]           length_bytes,
   input  logic [7:0]           first_zone,
   output mbpw_pkg::check_type  chk
);
   import mbpw_pkg::*;

   logic [3:0] count;
   logic [8:0] zone_b;
   logic       is_a;
   logic       is_b;

   always_comb begin
      count = '0;
      for (int j = 0; j < BAR_PIXELS; j++) begin
         if (mask[j]) count = count + 4'd1;
      end
      zone_b = {1'b0, first_zone} + 9'd1;   // no wrap: no bar B at 255
      is_a   = (zone == first_zone);
      is_b   = ({1'b0, zone} == zone_b);

      chk.status = ST_BAD_ZONE;
      chk.bar    = 1'b0;
      chk.write  = 1'b0;
      if (command == CMD_SHUTDOWN) begin
         chk.status = ST_SHUTDOWN;
      end else if (is_a || is_b) begin
         chk.bar = !is_a;
         if (mask[15:8] != '0) begin
            chk.status = ST_MASK_HIGH;
         end else if (length_bytes != {3'b0, count, 1'b0}) begin
            chk.status = ST_BAD_LENGTH;
         end else if (mask == '0) begin
            chk.status = ST_RELEASED;
         end else begin
            chk.status = ST_WRITTEN;
            chk.write  = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/mbpw_lane.sv
// One position lane: rank among set mask bits, colour pick, expand, map.
// Depends on mbpw_pkg.
`default_nettype none

module mbpw_lane (
   input  logic [2:0]               lane_idx,
   input  logic [7:0]               mask_low,
   input  mbpw_pkg::colour_vec_type colours,
   input  logic [23:0]              position_map,
   output mbpw_pkg::lane_type       lane
);
   import mbpw_pkg::*;

   logic [MAP_FIELDS-1:0][2:0] map_fields;
   logic [2:0]                 rank;

   assign map_fields = position_map;

   always_comb begin
      // rank = set bits below this position = which colour word it takes
      rank = '0;
      for (int j = 0; j < BAR_PIXELS; j++) begin
         if ((3'(j) < lane_idx) && mask_low[j]) rank = rank + 3'd1;
      end
      lane.phys = map_fields[lane_idx];
      lane.en   = mask_low[lane_idx] && ({1'b0, map_fields[lane_idx]} < 4'(BAR_PIXELS));
      lane.rgb  = expand565(colours[rank]);
   end

endmodule

`default_nettype wire

// File: rtl/mbpw_merge.sv
// Merges lane writes into one bar row; higher positions win on collision.
// Depends on mbpw_pkg.
`default_nettype none

module mbpw_merge (
   input  mbpw_pkg::lane_vec_type lanes,
   input  mbpw_pkg::row_type      old_row,
   input  logic                   written,
   output mbpw_pkg::row_type      new_row
);
   import mbpw_pkg::*;

   always_comb begin
      for (int p = 0; p < BAR_STRIDE; p++) begin
         new_row[p] = written ? old_row[p] : '0;   // unwritten bar starts black
         for (int l = 0; l < BAR_PIXELS; l++) begin
            if (lanes[l].en && (lanes[l].phys == 3'(p))) new_row[p] = lanes[l].rgb;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/masked_bar_pixel_writer_unit.sv
// Top level of the masked bar pixel writer: control, pixel store, output register.
// Depends on mbpw_pkg, mbpw_check, mbpw_lane, mbpw_merge and the macros header.
`default_nettype none
`include "masked_bar_pixel_writer_unit_macros.svh"

// Channel  Dir  Handshake            Word
// req_     in   req_valid/req_stall  command, zone, mask, length, eight RGB565 colours
// rsp_     out  rsp_valid/rsp_stall  status, bar, pixel index, RGB888, last
// csr_     in   csr_write            register index and data, no read-back
//
// A set-pixels word that writes passes the lane, merge and emit states before
// the next word can be accepted, one result per cycle going into the output
// register when it is free. Status-only words return to idle from the lane state.
// Output stalls hold the emit counter; the final result can sit in the output
// register while the next word is accepted. Reset clears both bars to black
// and both written marks, and returns the configuration registers to zone 0
// and the identity position map.

module masked_bar_pixel_writer_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_zone,
   input  logic [15:0] req_mask,
   input  logic [7:0]  req_length_bytes,
   input  logic [15:0] req_colour_0,
   input  logic [15:0] req_colour_1,
   input  logic [15:0] req_colour_2,
   input  logic [15:0] req_colour_3,
   input  logic [15:0] req_colour_4,
   input  logic [15:0] req_colour_5,
   input  logic [15:0] req_colour_6,
   input  logic [15:0] req_colour_7,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_bar,
   output logic [2:0]  rsp_pixel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,

   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import mbpw_pkg::*;

   localparam logic [2:0] LAST_PIX = 3'(BAR_PIXELS - 1);

   // control
   state_type      state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           req_accept;
   logic           out_free;
   logic           load_status;
   logic           load_pixel;
   logic           do_merge;

   // configuration
   logic [7:0]     first_zone_ff;
   logic [23:0]    pos_map_ff;

   // captured word
   logic           cmd_ff;
   logic [7:0]     zone_ff;
   logic [15:0]    mask_ff;
   logic [7:0]     len_ff;
   colour_vec_type colours_ff;

   // lanes, merge, store
   check_type      chk;
   lane_vec_type   lanes_w;
   lane_vec_type   lanes_ff;
   row_type        merged_row;
   row_type        pix_ff [NUM_BARS];
   logic [NUM_BARS-1:0] written_ff;

   // output register
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic           rsp_bar_ff;
   logic [2:0]     rsp_pixel_index_ff;
   rgb_type        rsp_rgb_ff;
   logic           rsp_last_ff;

   // check terms
   logic           rsp_status_only;
   logic           rsp_status_shape;
   logic           emit_start;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   mbpw_check u_check (
      .command      (cmd_ff),
      .zone         (zone_ff),
      .mask         (mask_ff),
      .length_bytes (len_ff),
      .first_zone   (first_zone_ff),
      .chk          (chk)
   );

   for (genvar i = 0; i < BAR_PIXELS; i++) begin : g_lane
      mbpw_lane u_lane (
         .lane_idx     (3'(i)),
         .mask_low     (mask_ff[7:0]),
         .colours      (colours_ff),
         .position_map (pos_map_ff),
         .lane         (lanes_w[i])
      );
   end

   mbpw_merge u_merge (
      .lanes   (lanes_ff),
      .old_row (pix_ff[chk.bar]),
      .written (written_ff[chk.bar]),
      .new_row (merged_row)
   );

   // next state and step controls
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      load_status = 1'b0;
      load_pixel  = 1'b0;
      do_merge    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_LANE;
         end
         S_LANE: begin
            if (chk.write) begin
               state_in = S_MERGE;
            end else if (out_free) begin
               load_status = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_MERGE: begin
            do_merge = 1'b1;
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load_pixel = 1'b1;
               cnt_in     = cnt_ff + 3'd1;
               if (cnt_ff == LAST_PIX) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_zone_ff <= FIRST_ZONE_RESET;
         pos_map_ff    <= POS_MAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FIRST_BAR_ZONE: first_zone_ff <= csr_wdata[7:0];
            REG_POSITION_MAP:   pos_map_ff    <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // word capture and lane register (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff     <= req_command;
         zone_ff    <= req_zone;
         mask_ff    <= req_mask;
         len_ff     <= req_length_bytes;
         colours_ff <= {req_colour_7, req_colour_6, req_colour_5, req_colour_4,
                        req_colour_3, req_colour_2, req_colour_1, req_colour_0};
      end
      if (state_ff == S_LANE) lanes_ff <= lanes_w;
   end

   // pixel store and written marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BARS; b++) pix_ff[b] <= '0;
         written_ff <= '0;
      end else if (do_merge) begin
         pix_ff[chk.bar]     <= merged_row;
         written_ff[chk.bar] <= 1'b1;
      end else if (load_status) begin
         if (chk.status == ST_SHUTDOWN) begin
            for (int b = 0; b < NUM_BARS; b++) pix_ff[b] <= '0;
            written_ff <= '0;
         end else if (chk.status == ST_RELEASED) begin
            written_ff[chk.bar] <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_status || load_pixel) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_status) begin
         rsp_status_ff      <= chk.status;
         rsp_bar_ff         <= chk.bar;
         rsp_pixel_index_ff <= '0;
         rsp_rgb_ff         <= '0;
         rsp_last_ff        <= 1'b1;
      end else if (load_pixel) begin
         rsp_status_ff      <= ST_WRITTEN;
         rsp_bar_ff         <= chk.bar;
         rsp_pixel_index_ff <= cnt_ff;
         rsp_rgb_ff         <= pix_ff[chk.bar][cnt_ff];
         rsp_last_ff        <= (cnt_ff == LAST_PIX);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bar         = rsp_bar_ff;
   assign rsp_pixel_index = rsp_pixel_index_ff;
   assign rsp_red         = rsp_rgb_ff[23:16];
   assign rsp_green       = rsp_rgb_ff[15:8];
   assign rsp_blue        = rsp_rgb_ff[7:0];
   assign rsp_last        = rsp_last_ff;

   // checks
   assign rsp_status_only  = rsp_valid && (rsp_status != ST_WRITTEN);
   assign rsp_status_shape = rsp_last && (rsp_pixel_index == 3'd0) && (rsp_red == 8'd0);
   assign emit_start       = written_ff[chk.bar] && (state_ff == S_EMIT) && (cnt_ff == 3'd0);

   `MBPW_ASSERT_NXT(a_accept_to_lane, clock, reset, req_accept, state_ff == S_LANE)
   `MBPW_ASSERT_IMP(a_status_only_shape, clock, reset, rsp_status_only, rsp_status_shape)
   `MBPW_ASSERT_NXT(a_merge_marks_bar, clock, reset, state_ff == S_MERGE, emit_start)

endmodule

`default_nettype wire

// File: sim/tb_masked_bar_pixel_writer_unit.sv
// Testbench for masked_bar_pixel_writer_unit: directed and random set-pixels/shutdown words,
// checked result by result against a scoreboard built from the block's behavior.
// Depends on mbpw_pkg and the RTL top level only.
`default_nettype none

module tb_masked_bar_pixel_writer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mbpw_pkg::*;

   // one request word, colours kept as an array for the predictor
   typedef struct {
      logic        command;
      logic [7:0]  zone;
      logic [15:0] mask;
      logic [7:0]  length_bytes;
      logic [15:0] colour [8];
   } req_word_type;

   // one response word
   typedef struct {
      status_type status;
      logic       bar;
      logic [2:0] pixel;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [7:0]  req_zone = '0;
   logic [15:0] req_mask = '0;
   logic [7:0]  req_length_bytes = '0;
   logic [15:0] req_colour_0 = '0;
   logic [15:0] req_colour_1 = '0;
   logic [15:0] req_colour_2 = '0;
   logic [15:0] req_colour_3 = '0;
   logic [15:0] req_colour_4 = '0;
   logic [15:0] req_colour_5 = '0;
   logic [15:0] req_colour_6 = '0;
   logic [15:0] req_colour_7 = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_bar;
   logic [2:0]  rsp_pixel_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_last;

   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [23:0] csr_wdata = '0;

   // predictor state: configuration, pixel store, written marks
   logic [7:0]    cfg_zone = FIRST_ZONE_RESET;
   logic [23:0]   cfg_map  = POS_MAP_RESET;
   rgb_type       bar_store [2][8];
   bit            bar_marked [2];

   pixel_result_type expected_results [$];
   int            errors = 0;
   bit            quiet = 1'b0;      // no idling on either side
   int            stall_left = 0;

   masked_bar_pixel_writer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_zone         (req_zone),
      .req_mask         (req_mask),
      .req_length_bytes (req_length_bytes),
      .req_colour_0     (req_colour_0),
      .req_colour_1     (req_colour_1),
      .req_colour_2     (req_colour_2),
      .req_colour_3     (req_colour_3),
      .req_colour_4     (req_colour_4),
      .req_colour_5     (req_colour_5),
      .req_colour_6     (req_colour_6),
      .req_colour_7     (req_colour_7),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bar          (rsp_bar),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int b = 0; b < 2; b++) begin
         bar_marked[b] = 1'b0;
         for (int p = 0; p < 8; p++) bar_store[b][p] = '0;
      end
   end

   // ---------------------------------------------------------------- predictor

   // RGB565 to RGB888, channel * 255 / max with truncation
   function automatic rgb_type widen_565(input logic [15:0] c);
      int r, g, b;
      r = int'(c[15:11]) * 255 / 31;
      g = int'(c[10:5]) * 255 / 63;
      b = int'(c[4:0]) * 255 / 31;
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   function automatic void queue_result(input status_type st, input logic bar,
                                        input logic [2:0] pix, input rgb_type rgb,
                                        input logic last);
      pixel_result_type r;
      r.status = st;
      r.bar    = bar;
      r.pixel  = pix;
      r.red    = rgb[23:16];
      r.green  = rgb[15:8];
      r.blue   = rgb[7:0];
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   // updates the bar store for one accepted word and queues what it emits
   function automatic void forecast_results(input req_word_type w);
      int          bar;
      int          cnt;
      int          ofs;
      logic [2:0]  phys;
      if (w.command == CMD_SHUTDOWN) begin
         for (int b = 0; b < 2; b++) begin
            bar_marked[b] = 1'b0;
            for (int p = 0; p < 8; p++) bar_store[b][p] = '0;
         end
         queue_result(ST_SHUTDOWN, 1'b0, 3'd0, '0, 1'b1);
         return;
      end
      // bar B code is computed without wrap
      if (w.zone == cfg_zone) bar = 0;
      else if ({1'b0, w.zone} == {1'b0, cfg_zone} + 9'd1) bar = 1;
      else begin
         queue_result(ST_BAD_ZONE, 1'b0, 3'd0, '0, 1'b1);
         return;
      end
      if (w.mask[15:8] != 8'h00) begin
         queue_result(ST_MASK_HIGH, 1'(bar), 3'd0, '0, 1'b1);
         return;
      end
      cnt = 0;
      for (int pos = 0; pos < BAR_PIXELS; pos++) if (w.mask[pos]) cnt++;
      if (int'(w.length_bytes) != 2 * cnt) begin
         queue_result(ST_BAD_LENGTH, 1'(bar), 3'd0, '0, 1'b1);
         return;
      end
      if (w.mask == 16'h0000) begin
         // release only: pixels keep their values
         bar_marked[bar] = 1'b0;
         queue_result(ST_RELEASED, 1'(bar), 3'd0, '0, 1'b1);
         return;
      end
      if (!bar_marked[bar])
         for (int p = 0; p < 8; p++) bar_store[bar][p] = '0;
      bar_marked[bar] = 1'b1;
      // k-th set position takes colour k; out-of-range map entries still use one
      ofs = 0;
      for (int pos = 0; pos < BAR_PIXELS; pos++) begin
         if (w.mask[pos]) begin
            phys = cfg_map[3*pos +: 3];
            if (int'(phys) < BAR_PIXELS && ofs < 8)
               bar_store[bar][phys] = widen_565(w.colour[ofs]);
            ofs++;
         end
      end
      for (int p = 0; p < BAR_PIXELS; p++)
         queue_result(ST_WRITTEN, 1'(bar), 3'(p), bar_store[bar][p],
                      1'(p + 1 == BAR_PIXELS));
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // results sampled at the rising edge, compared with the oldest expectation
   always @(posedge clock) begin : check_rsp
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with none pending, status", int'(rsp_status), 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_bar !== want.bar)
               report_mismatch("bar", int'(rsp_bar), int'(want.bar));
            if (rsp_pixel_index !== want.pixel)
               report_mismatch("pixel_index", int'(rsp_pixel_index), int'(want.pixel));
            if (rsp_red !== want.red)
               report_mismatch("red", int'(rsp_red), int'(want.red));
            if (rsp_green !== want.green)
               report_mismatch("green", int'(rsp_green), int'(want.green));
            if (rsp_blue !== want.blue)
               report_mismatch("blue", int'(rsp_blue), int'(want.blue));
            if (rsp_last !== want.last)
               report_mismatch("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   // receiver back-pressure in random bursts of random length
   always @(negedge clock) begin
      if (quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- driving

   // drives one word at the falling edge, maybe after an idle burst,
   // and holds it until accepted at a rising edge
   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command      <= w.command;
      req_zone         <= w.zone;
      req_mask         <= w.mask;
      req_length_bytes <= w.length_bytes;
      req_colour_0     <= w.colour[0];
      req_colour_1     <= w.colour[1];
      req_colour_2     <= w.colour[2];
      req_colour_3     <= w.colour[3];
      req_colour_4     <= w.colour[4];
      req_colour_5     <= w.colour[5];
      req_colour_6     <= w.colour[6];
      req_colour_7     <= w.colour[7];
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      forecast_results(w);
   endtask

   // drop valid and wait until every pending result is out, plus a margin
   task automatic wait_bar_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // only called while the block is idle
   task automatic write_reg(input logic idx, input logic [23:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == REG_FIRST_BAR_ZONE) cfg_zone = data[7:0];
      else cfg_map = data;
   endtask

   function automatic req_word_type build_word(input logic cmd, input logic [7:0] zone,
                                               input logic [15:0] mask,
                                               input logic [7:0] len);
      req_word_type w;
      w.command      = cmd;
      w.zone         = zone;
      w.mask         = mask;
      w.length_bytes = len;
      for (int i = 0; i < 8; i++) w.colour[i] = 16'($urandom);
      return w;
   endfunction

   // set-pixels word that passes every check, aimed at bar A (0) or B (1)
   function automatic req_word_type well_formed(input logic b, input logic [7:0] m);
      return build_word(CMD_SET_PIXELS, 8'(cfg_zone + b), {8'h00, m}, 8'(2 * $countones(m)));
   endfunction

   function automatic req_word_type random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return well_formed(1'($urandom), 8'($urandom));
      else if (pick < 75)
         return well_formed(1'($urandom), 8'h00);
      else if (pick < 80)
         return build_word(CMD_SHUTDOWN, 8'($urandom), 16'($urandom), 8'($urandom));
      else if (pick < 90)
         // right zone, broken mask or length
         return build_word(CMD_SET_PIXELS, 8'(cfg_zone + $urandom_range(0, 1)),
                           16'($urandom), 8'($urandom));
      else
         return build_word(CMD_SET_PIXELS, 8'($urandom), 16'($urandom), 8'($urandom));
   endfunction

   // ---------------------------------------------------------------- tests

   // full and partial writes after reset, colour extremes
   task automatic test_bar_writes();
      req_word_type w;
      w = well_formed(1'b0, 8'hFF);
      w.colour[0] = 16'h0000;
      w.colour[1] = 16'hFFFF;
      w.colour[2] = 16'hF800;
      w.colour[3] = 16'h07E0;
      w.colour[4] = 16'h001F;
      w.colour[5] = 16'h8410;
      w.colour[6] = 16'h7BEF;
      send_word(w);
      send_word(well_formed(1'b1, 8'h01));
      send_word(well_formed(1'b0, 8'h80));     // written bar keeps other pixels
      send_word(well_formed(1'b1, 8'hA5));
   endtask

   // rejects, their precedence, and release of a bar
   task automatic test_rejects();
      send_word(build_word(CMD_SET_PIXELS, 8'(cfg_zone + 2), 16'hFFFF, 8'hFF));
      send_word(build_word(CMD_SET_PIXELS, 8'hFF, 16'h0001, 8'd2));
      send_word(build_word(CMD_SET_PIXELS, cfg_zone, 16'h0100, 8'd0));
      send_word(build_word(CMD_SET_PIXELS, 8'(cfg_zone + 1), 16'hFF01, 8'd3));
      send_word(build_word(CMD_SET_PIXELS, cfg_zone, 16'h0003, 8'd3));
      send_word(build_word(CMD_SET_PIXELS, 8'(cfg_zone + 1), 16'h00FF, 8'hFF));
      send_word(build_word(CMD_SET_PIXELS, cfg_zone, 16'h0000, 8'd1));
      send_word(well_formed(1'b0, 8'h00));
      // released bar is blacked before the next write
      send_word(well_formed(1'b0, 8'h04));
   endtask

   task automatic test_shutdown();
      send_word(build_word(CMD_SHUTDOWN, 8'($urandom), 16'($urandom), 8'($urandom)));
      send_word(well_formed(1'b1, 8'h10));
      send_word(build_word(CMD_SHUTDOWN, 8'h00, 16'h0000, 8'h00));
      send_word(well_formed(1'b0, 8'h42));
   endtask

   // zone at its top value, reversed / collapsed / all-ones position maps
   task automatic test_map_and_zone_extremes();
      logic [23:0] rev_map;
      for (int i = 0; i < 8; i++) rev_map[3*i +: 3] = 3'(7 - i);
      wait_bar_idle();
      write_reg(REG_FIRST_BAR_ZONE, 24'd254);
      write_reg(REG_POSITION_MAP, rev_map);
      send_word(well_formed(1'b0, 8'hFF));
      send_word(well_formed(1'b1, 8'h3C));
      send_word(build_word(CMD_SET_PIXELS, 8'd253, 16'h0001, 8'd2));
      wait_bar_idle();
      // every position lands on pixel 0, the last one wins
      write_reg(REG_POSITION_MAP, 24'h000000);
      write_reg(REG_FIRST_BAR_ZONE, 24'd0);
      send_word(well_formed(1'b0, 8'hFF));
      wait_bar_idle();
      write_reg(REG_POSITION_MAP, 24'hFFFFFF);
      send_word(well_formed(1'b1, 8'h81));
      wait_bar_idle();
      write_reg(REG_POSITION_MAP, POS_MAP_RESET);
   endtask

   // mostly well-formed writes with random content, some noise; an occasional
   // full drain keeps the sender waiting until every result is out
   task automatic test_random_traffic(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 24) == 0) wait_bar_idle();
         send_word(random_word());
      end
      wait_bar_idle();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_bar_writes();
      test_rejects();
      test_shutdown();
      test_map_and_zone_extremes();

      write_reg(REG_FIRST_BAR_ZONE, 24'($urandom_range(0, 254)));
      write_reg(REG_POSITION_MAP, 24'($urandom));
      test_random_traffic(50);

      write_reg(REG_FIRST_BAR_ZONE, 24'd0);
      write_reg(REG_POSITION_MAP, 24'($urandom));
      test_random_traffic(40);

      // last stretch with no idling on either side
      quiet = 1'b1;
      write_reg(REG_FIRST_BAR_ZONE, 24'd254);
      write_reg(REG_POSITION_MAP, POS_MAP_RESET);
      test_random_traffic(35);

      repeat (20) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results still pending", 0, expected_results.size());
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
